@@ rtl/keyboard_scancode_translator_macros.svh @@
// Assertion macros shared by the keyboard scancode translator checkers.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef KEYBOARD_SCANCODE_TRANSLATOR_MACROS_SVH
`define KEYBOARD_SCANCODE_TRANSLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyboard translator check failed");

// The consequent must hold in the cycle after the antecedent.
`define KST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyboard translator check failed");

`endif

@@ rtl/kst_pkg.sv @@
// Package for the keyboard scancode translator: sizes, codes, key tables and
// the structs passed between the decode, buffer and top-level modules.
// No dependencies.
package kst_pkg;

    localparam int BUF_DEPTH   = 16;
    localparam int PTR_W       = $clog2(BUF_DEPTH);
    localparam int CNT_W       = $clog2(BUF_DEPTH);
    localparam int CHAR_W      = 7;
    localparam int PAGE_W      = 3;
    localparam int START_W     = 14;
    localparam int PAGE_STRIDE = 2000;

    localparam logic [1:0] KIND_SCAN = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_PEEK = 2'd2;

    localparam logic [6:0] SC_CTRL   = 7'h1D;
    localparam logic [6:0] SC_LSHIFT = 7'h2A;
    localparam logic [6:0] SC_RSHIFT = 7'h36;
    localparam logic [6:0] SC_F1     = 7'h3B;
    localparam logic [6:0] SC_F8     = 7'h42;

    typedef struct packed {
        logic              push;
        logic [CHAR_W-1:0] ch;
        logic              rd;
        logic              pop;
        logic              page_evt;
        logic [PAGE_W-1:0] page;
    } dec_t;

    typedef struct packed {
        logic [CHAR_W-1:0] head;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  cnt_next;
    } fifo_stat_t;

    function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] code);
        logic [CHAR_W-1:0] c;
        unique case (code)
            7'h01: c = 7'h1B;
            7'h02: c = 7'h31;
            7'h03: c = 7'h32;
            7'h04: c = 7'h33;
            7'h05: c = 7'h34;
            7'h06: c = 7'h35;
            7'h07: c = 7'h36;
            7'h08: c = 7'h37;
            7'h09: c = 7'h38;
            7'h0A: c = 7'h39;
            7'h0B: c = 7'h30;
            7'h0C: c = 7'h2D;
            7'h0D: c = 7'h3D;
            7'h0E: c = 7'h08;
            7'h0F: c = 7'h09;
            7'h10: c = 7'h71;
            7'h11: c = 7'h77;
            7'h12: c = 7'h65;
            7'h13: c = 7'h72;
            7'h14: c = 7'h74;
            7'h15: c = 7'h79;
            7'h16: c = 7'h75;
            7'h17: c = 7'h69;
            7'h18: c = 7'h6F;
            7'h19: c = 7'h70;
            7'h1A: c = 7'h5B;
            7'h1B: c = 7'h5D;
            7'h1C: c = 7'h0D;
            7'h1E: c = 7'h61;
            7'h1F: c = 7'h73;
            7'h20: c = 7'h64;
            7'h21: c = 7'h66;
            7'h22: c = 7'h67;
            7'h23: c = 7'h68;
            7'h24: c = 7'h6A;
            7'h25: c = 7'h6B;
            7'h26: c = 7'h6C;
            7'h27: c = 7'h3B;
            7'h28: c = 7'h27;
            7'h29: c = 7'h60;
            7'h2B: c = 7'h5C;
            7'h2C: c = 7'h7A;
            7'h2D: c = 7'h78;
            7'h2E: c = 7'h63;
            7'h2F: c = 7'h76;
            7'h30: c = 7'h62;
            7'h31: c = 7'h6E;
            7'h32: c = 7'h6D;
            7'h33: c = 7'h2C;
            7'h34: c = 7'h2E;
            7'h35: c = 7'h2F;
            7'h37: c = 7'h2A;
            7'h39: c = 7'h20;
            7'h47: c = 7'h37;
            7'h48: c = 7'h38;
            7'h49: c = 7'h39;
            7'h4A: c = 7'h2D;
            7'h4B: c = 7'h34;
            7'h4C: c = 7'h35;
            7'h4D: c = 7'h36;
            7'h4E: c = 7'h2B;
            7'h4F: c = 7'h31;
            7'h50: c = 7'h32;
            7'h51: c = 7'h33;
            7'h52: c = 7'h30;
            7'h53: c = 7'h2E;
            7'h56: c = 7'h5A;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Keys whose shifted character differs; every other key keeps its plain one.
    function automatic logic [CHAR_W-1:0] shifted_char(input logic [6:0] code);
        logic [CHAR_W-1:0] c;
        unique case (code)
            7'h02: c = 7'h21;
            7'h03: c = 7'h40;
            7'h04: c = 7'h23;
            7'h05: c = 7'h24;
            7'h06: c = 7'h25;
            7'h07: c = 7'h5E;
            7'h08: c = 7'h26;
            7'h09: c = 7'h2A;
            7'h0A: c = 7'h28;
            7'h0B: c = 7'h29;
            7'h0C: c = 7'h5F;
            7'h0D: c = 7'h2B;
            7'h10: c = 7'h51;
            7'h11: c = 7'h57;
            7'h12: c = 7'h45;
            7'h13: c = 7'h52;
            7'h14: c = 7'h54;
            7'h15: c = 7'h59;
            7'h16: c = 7'h55;
            7'h17: c = 7'h49;
            7'h18: c = 7'h4F;
            7'h19: c = 7'h50;
            7'h1A: c = 7'h7B;
            7'h1B: c = 7'h7D;
            7'h1E: c = 7'h41;
            7'h1F: c = 7'h53;
            7'h20: c = 7'h44;
            7'h21: c = 7'h46;
            7'h22: c = 7'h47;
            7'h23: c = 7'h48;
            7'h24: c = 7'h4A;
            7'h25: c = 7'h4B;
            7'h26: c = 7'h4C;
            7'h27: c = 7'h3A;
            7'h28: c = 7'h22;
            7'h29: c = 7'h7E;
            7'h2B: c = 7'h7C;
            7'h2C: c = 7'h5A;
            7'h2D: c = 7'h58;
            7'h2E: c = 7'h43;
            7'h2F: c = 7'h56;
            7'h30: c = 7'h42;
            7'h31: c = 7'h4E;
            7'h32: c = 7'h4D;
            7'h33: c = 7'h3C;
            7'h34: c = 7'h3E;
            7'h35: c = 7'h3F;
            default: c = plain_char(code);
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] control_char(input logic [6:0] code);
        logic [CHAR_W-1:0] c;
        unique case (code)
            7'h10: c = 7'd17;
            7'h11: c = 7'd23;
            7'h12: c = 7'd5;
            7'h13: c = 7'd18;
            7'h14: c = 7'd20;
            7'h15: c = 7'd25;
            7'h16: c = 7'd21;
            7'h17: c = 7'd9;
            7'h18: c = 7'd15;
            7'h19: c = 7'd16;
            7'h1E: c = 7'd1;
            7'h1F: c = 7'd19;
            7'h20: c = 7'd4;
            7'h21: c = 7'd6;
            7'h22: c = 7'd7;
            7'h23: c = 7'd8;
            7'h24: c = 7'd10;
            7'h25: c = 7'd11;
            7'h26: c = 7'd12;
            7'h2C: c = 7'd26;
            7'h2D: c = 7'd24;
            7'h2E: c = 7'd3;
            7'h2F: c = 7'd22;
            7'h30: c = 7'd2;
            7'h31: c = 7'd14;
            7'h32: c = 7'd13;
            default: c = 7'd0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/kst_decode.sv @@
// Scancode decode for the keyboard translator: modifier flags, key tables
// and F1-F8 page selection. Depends on kst_pkg.
module kst_decode
    import kst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [1:0] kind,
    input  logic [7:0] scancode,
    output dec_t       dec
);

    logic              shift_reg, shift_next;
    logic              ctrl_reg, ctrl_next;
    logic [6:0]        code;
    logic [6:0]        page_off;
    logic              make;
    logic [CHAR_W-1:0] plain;
    logic [CHAR_W-1:0] ch;

    assign code     = scancode[6:0];
    assign make     = !scancode[7];
    assign plain    = plain_char(code);
    assign page_off = code - SC_F1;

    always_comb
    begin
        shift_next   = shift_reg;
        ctrl_next    = ctrl_reg;
        dec          = '0;
        ch           = plain;
        if (ctrl_reg)
        begin
            ch = control_char(code);
        end
        else if (shift_reg)
        begin
            ch = shifted_char(code);
        end
        unique case (kind)
            KIND_SCAN:
            begin
                if (make && plain != '0)
                begin
                    dec.push = (ch != '0);
                    dec.ch   = ch;
                end
                else
                begin
                    if (code == SC_CTRL)
                    begin
                        ctrl_next = make;
                    end
                    else if (code == SC_LSHIFT || code == SC_RSHIFT)
                    begin
                        shift_next = make;
                    end
                    if (code >= SC_F1 && code <= SC_F8)
                    begin
                        dec.page_evt = 1'b1;
                        dec.page     = page_off[PAGE_W-1:0];
                    end
                end
            end
            KIND_READ:
            begin
                dec.rd  = 1'b1;
                dec.pop = 1'b1;
            end
            KIND_PEEK:
            begin
                dec.rd = 1'b1;
            end
            default:
            begin
                dec = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
        end
        else if (en)
        begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
        end
    end

endmodule

@@ rtl/kst_fifo.sv @@
// Character ring buffer for the keyboard translator; a push into a full ring
// drops the oldest character. Depends on kst_pkg.
module kst_fifo
    import kst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              push,
    input  logic [CHAR_W-1:0] ch,
    input  logic              pop,
    output fifo_stat_t        stat
);

    logic [CHAR_W-1:0] store_reg [BUF_DEPTH];
    logic [PTR_W-1:0]  rd_reg, rd_next, rd_inc;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PTR_W:0]    wr_sum;
    logic [PTR_W-1:0]  wr_slot;

    assign wr_sum  = {1'b0, rd_reg} + (PTR_W + 1)'(cnt_reg);
    assign wr_slot = (wr_sum >= (PTR_W + 1)'(BUF_DEPTH)) ?
                     PTR_W'(wr_sum - (PTR_W + 1)'(BUF_DEPTH)) : wr_sum[PTR_W-1:0];
    assign rd_inc  = (rd_reg == PTR_W'(BUF_DEPTH - 1)) ? '0 : rd_reg + 1'b1;

    always_comb
    begin
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            if (cnt_reg == CNT_W'(BUF_DEPTH - 1))
            begin
                rd_next = rd_inc;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else if (pop && cnt_reg != '0)
        begin
            rd_next  = rd_inc;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    assign stat.head     = store_reg[rd_reg];
    assign stat.cnt      = cnt_reg;
    assign stat.cnt_next = cnt_next;

    always_ff @(posedge clk)
    begin
        if (en && push)
        begin
            store_reg[wr_slot] <= ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (en)
        begin
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ rtl/keyboard_scancode_translator.sv @@
// Keyboard scancode translator: set-1 scancodes in, buffered ASCII out.
// Built from kst_decode and kst_fifo; depends on kst_pkg.
//
// The input channel takes one word per cycle while in_ready is high: kind
// selects a scancode arrival, a read that removes the oldest buffered
// character, or a peek that leaves it. Every input word gives exactly one
// output word with the character read, any F1-F8 page selection with its
// start offset, and the buffer fill level. A word is taken into the input
// register, then decoded and applied to the buffer as it is written to the
// output register. Throughput is one word per cycle while out_ready is high;
// the ring buffer and the modifier flags are read and updated together.
// When the receiver stalls, the output register holds its word and the input
// register can still take one more word before in_ready drops.
// Reset clears the modifier flags, the buffer count and read pointer, and both
// valid flags; the character storage itself is not cleared.
module keyboard_scancode_translator
    import kst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [7:0]         scancode,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  out_char,
    output logic               page_change,
    output logic [PAGE_W-1:0]  page_number,
    output logic [START_W-1:0] page_start,
    output logic [3:0]         fill_level
);

    logic               in_valid_reg;
    logic [1:0]         kind_reg;
    logic [7:0]         scancode_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic               page_change_reg;
    logic [PAGE_W-1:0]  page_number_reg;
    logic [START_W-1:0] page_start_reg, page_start_next;
    logic [3:0]         fill_level_reg;
    logic               advance;
    dec_t               dec;
    fifo_stat_t         stat;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    kst_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .kind     (kind_reg),
        .scancode (scancode_reg),
        .dec      (dec)
    );

    kst_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .push  (dec.push),
        .ch    (dec.ch),
        .pop   (dec.pop),
        .stat  (stat)
    );

    assign out_char_next   = (dec.rd && stat.cnt != '0) ? stat.head : '0;
    assign page_start_next = START_W'(dec.page) * START_W'(PAGE_STRIDE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg     <= kind;
            scancode_reg <= scancode;
        end
        if (advance)
        begin
            out_char_reg    <= out_char_next;
            page_change_reg <= dec.page_evt;
            page_number_reg <= dec.page;
            page_start_reg  <= page_start_next;
            fill_level_reg  <= 4'(stat.cnt_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign page_change = page_change_reg;
    assign page_number = page_number_reg;
    assign page_start  = page_start_reg;
    assign fill_level  = fill_level_reg;

endmodule

@@ rtl/kst_checker.sv @@
// Port-level checks for the keyboard scancode translator, bound to its top.
// Depends on keyboard_scancode_translator_macros.svh.
`include "keyboard_scancode_translator_macros.svh"

module kst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  kind,
    input logic [7:0]  scancode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [6:0]  out_char,
    input logic        page_change,
    input logic [2:0]  page_number,
    input logic [13:0] page_start,
    input logic [3:0]  fill_level
);

    logic [13:0] expect_start;

    assign expect_start = 14'(page_number) * 14'd2000;

    `KST_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(kind) && $stable(scancode))
    `KST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(fill_level) && $stable(page_start))
    `KST_ASSERT_NOW(a_no_page_zero, out_valid && !page_change, page_number == 3'd0 && page_start == 14'd0)
    `KST_ASSERT_NOW(a_page_start, out_valid && page_change, page_start == expect_start)
    `KST_ASSERT_NOW(a_char_no_page, out_valid && out_char != 7'd0, !page_change)

endmodule

bind keyboard_scancode_translator kst_checker u_kst_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for keyboard_scancode_translator: predicts every output word
// from its own key tables and buffer model, and checks it against the block.
// Depends on kst_pkg and the translator RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kst_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [7:0] SC_RELEASE  = 8'h80;
    localparam int         WORD_TARGET = 826;
    localparam int         PHASE_WORDS = 100;
    localparam int         CYCLE_LIMIT = 400000;

    localparam logic [0:87][7:0] PLAIN_MAP = {
        64'h001B313233343536, 64'h373839302D3D0809, 64'h7177657274797569,
        64'h6F705B5D0D006173, 64'h646667686A6B6C3B, 64'h2760005C7A786376,
        64'h626E6D2C2E2F002A, 64'h0020000000000000, 64'h0000000000000037,
        64'h38392D3435362B31, 64'h3233302E00005A00
    };

    localparam logic [0:55][7:0] SHIFT_MAP = {
        64'h001B21402324255E, 64'h262A28295F2B0809, 64'h5157455254595549,
        64'h4F507B7D0D004153, 64'h444647484A4B4C3A, 64'h227E007C5A584356,
        64'h424E4D3C3E3F002A
    };

    localparam logic [0:55][7:0] CTRL_MAP = {
        64'h0000000000000000, 64'h0000000000000000, 64'h1117051214191509,
        64'h0F10000000000113, 64'h040607080A0B0C00, 64'h000000001A180316,
        64'h020E0D0000000000
    };

    typedef struct {
        logic [CHAR_W-1:0]  ch;
        logic               page_hit;
        logic [PAGE_W-1:0]  page_num;
        logic [START_W-1:0] page_ofs;
        logic [3:0]         fill;
    } key_word_t;

    class kbd_translation_board;
        logic [CHAR_W-1:0] chars [BUF_DEPTH];
        int unsigned       held;
        int unsigned       head;
        bit                shift_on;
        bit                ctrl_on;
        key_word_t         due_words [$];
        int                errors;

        function new();
            held     = 0;
            head     = 0;
            shift_on = 1'b0;
            ctrl_on  = 1'b0;
            errors   = 0;
        endfunction

        function logic [CHAR_W-1:0] plain_of(logic [6:0] code);
            if (code < 7'd88)
                return PLAIN_MAP[code][CHAR_W-1:0];
            return '0;
        endfunction

        function logic [CHAR_W-1:0] shifted_of(logic [6:0] code);
            if (code < 7'd56)
                return SHIFT_MAP[code][CHAR_W-1:0];
            return plain_of(code);
        endfunction

        function logic [CHAR_W-1:0] control_of(logic [6:0] code);
            if (code < 7'd56)
                return CTRL_MAP[code][CHAR_W-1:0];
            return '0;
        endfunction

        function void push_char(logic [CHAR_W-1:0] c);
            chars[(head + held) % BUF_DEPTH] = c;
            held++;
            if (held >= BUF_DEPTH) begin
                head = (head + 1) % BUF_DEPTH;
                held--;
            end
        endfunction

        function void note_word(logic [1:0] k, logic [7:0] sc);
            key_word_t         w;
            logic [6:0]        code;
            logic [CHAR_W-1:0] c;
            bit                make;
            int                page;
            w.ch       = '0;
            w.page_hit = 1'b0;
            w.page_num = '0;
            w.page_ofs = '0;
            code       = sc[6:0];
            make       = (sc & SC_RELEASE) == 8'h00;
            if (k == KIND_SCAN) begin
                if (make && plain_of(code) != '0) begin
                    c = plain_of(code);
                    if (shift_on)
                        c = shifted_of(code);
                    if (ctrl_on)
                        c = control_of(code);
                    if (c != '0)
                        push_char(c);
                end
                else begin
                    if (code == SC_CTRL)
                        ctrl_on = make;
                    else if (code == SC_LSHIFT || code == SC_RSHIFT)
                        shift_on = make;
                    if (code >= SC_F1 && code <= SC_F8) begin
                        page       = int'(code - SC_F1);
                        w.page_hit = 1'b1;
                        w.page_num = PAGE_W'(page);
                        w.page_ofs = START_W'(page * PAGE_STRIDE);
                    end
                end
            end
            else if ((k == KIND_READ || k == KIND_PEEK) && held != 0) begin
                w.ch = chars[head];
                if (k == KIND_READ) begin
                    head = (head + 1) % BUF_DEPTH;
                    held--;
                end
            end
            w.fill = 4'(held);
            due_words.push_back(w);
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic [CHAR_W-1:0] ch, logic hit, logic [PAGE_W-1:0] num,
                                 logic [START_W-1:0] ofs, logic [3:0] fill);
            key_word_t w;
            if (due_words.size() == 0) begin
                $display("%0t: no word expected, actual char %0d page %0d/%0d/%0d fill %0d",
                         $time, ch, hit, num, ofs, fill);
                errors++;
                return;
            end
            w = due_words.pop_front();
            compare("out_char", 16'(w.ch), 16'(ch));
            compare("page_change", 16'(w.page_hit), 16'(hit));
            compare("page_number", 16'(w.page_num), 16'(num));
            compare("page_start", 16'(w.page_ofs), 16'(ofs));
            compare("fill_level", 16'(w.fill), 16'(fill));
        endfunction

        function int pending();
            return due_words.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         kind = KIND_SCAN;
    logic [7:0]         scancode = 8'h00;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CHAR_W-1:0]  out_char;
    logic               page_change;
    logic [PAGE_W-1:0]  page_number;
    logic [START_W-1:0] page_start;
    logic [3:0]         fill_level;

    kbd_translation_board board = new();
    bit                   in_steady = 1'b0;
    bit                   out_steady = 1'b0;
    int                   words_sent = 0;
    int                   cycle_count = 0;

    keyboard_scancode_translator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .scancode    (scancode),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .page_change (page_change),
        .page_number (page_number),
        .page_start  (page_start),
        .fill_level  (fill_level)
    );

    always #6ns clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic [1:0] k, input logic [7:0] sc);
        in_valid <= 1'b1;
        kind     <= k;
        scancode <= sc;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_word(k, sc);
        words_sent++;
    endtask

    task automatic pace_in();
        int n;
        n = in_steady ? 0 : gap_len();
        if (n > 0) begin
            in_valid <= 1'b0;
            kind     <= 2'($urandom);
            scancode <= 8'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_paced(input logic [1:0] k, input logic [7:0] sc);
        send_word(k, sc);
        pace_in();
    endtask

    initial
    begin : sink
        int stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_word(out_char, page_change, page_number, page_start, fill_level);
            if (!rst_n || (!out_steady && stall > 0)) begin
                out_ready <= 1'b0;
                if (stall > 0)
                    stall--;
            end
            else begin
                out_ready <= 1'b1;
                if (!out_steady)
                    stall = gap_len();
            end
        end
    end

    initial
    begin : stimulus
        int         r;
        int         read_share;
        int         next_phase;
        logic [6:0] key;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_paced(KIND_READ, 8'h00);
        send_paced(KIND_PEEK, 8'hFF);
        send_paced(KIND_UNUSED, 8'hFF);
        send_paced(KIND_SCAN, 8'h00);
        send_paced(KIND_SCAN, 8'h80);
        send_paced(KIND_SCAN, 8'h1E);
        send_paced(KIND_PEEK, 8'h00);
        send_paced(KIND_SCAN, {1'b0, SC_LSHIFT});
        send_paced(KIND_SCAN, 8'h1E);
        send_paced(KIND_SCAN, 8'h27);
        send_paced(KIND_SCAN, {1'b1, SC_LSHIFT});
        send_paced(KIND_SCAN, {1'b0, SC_RSHIFT});
        send_paced(KIND_SCAN, 8'h02);
        send_paced(KIND_SCAN, {1'b1, SC_RSHIFT});
        send_paced(KIND_SCAN, {1'b0, SC_CTRL});
        send_paced(KIND_SCAN, 8'h1E);
        send_paced(KIND_SCAN, 8'h02);
        send_paced(KIND_SCAN, {1'b0, SC_LSHIFT});
        send_paced(KIND_SCAN, 8'h10);
        send_paced(KIND_SCAN, {1'b1, SC_CTRL});
        send_paced(KIND_SCAN, {1'b1, SC_LSHIFT});
        send_paced(KIND_SCAN, {1'b0, SC_F1});
        send_paced(KIND_SCAN, {1'b1, SC_F8});
        send_paced(KIND_SCAN, 8'h7F);
        send_paced(KIND_READ, 8'h00);
        send_paced(KIND_SCAN, 8'hFF);
        wait_drained();

        read_share = 10;
        next_phase = words_sent;
        while (words_sent < WORD_TARGET) begin
            if (words_sent >= next_phase) begin
                if ($urandom_range(0, 1) == 0)
                    wait_drained();
                case ($urandom_range(0, 2))
                    0: read_share = 8;
                    1: read_share = 30;
                    default: read_share = 55;
                endcase
                in_steady  = $urandom_range(0, 3) == 0;
                out_steady = $urandom_range(0, 3) == 0;
                next_phase = words_sent + PHASE_WORDS;
            end
            r = $urandom_range(0, 99);
            if (r < read_share) begin
                send_paced(($urandom_range(0, 3) == 0) ? KIND_PEEK : KIND_READ, 8'($urandom));
            end
            else if (r < read_share + 12) begin
                case ($urandom_range(0, 2))
                    0: key = SC_CTRL;
                    1: key = SC_LSHIFT;
                    default: key = SC_RSHIFT;
                endcase
                send_paced(KIND_SCAN, {1'($urandom_range(0, 1)), key});
            end
            else if (r < read_share + 20) begin
                key = SC_F1 + 7'($urandom_range(0, 7));
                send_paced(KIND_SCAN, {1'b0, key});
                send_paced(KIND_SCAN, {1'b1, key});
            end
            else if (r < read_share + 26) begin
                send_paced(2'($urandom), 8'($urandom));
            end
            else begin
                key = 7'($urandom_range(1, 8'h58));
                send_paced(KIND_SCAN, {1'b0, key});
                if ($urandom_range(0, 3) != 0)
                    send_paced(KIND_SCAN, {1'b1, key});
            end
        end

        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
